FILE: design/espc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espc_pkg
// Shared types, codes and reset constants of the encoder servo pulse
// controller.
// ----------------------------------------------------------------------------
package espc_pkg;

    localparam int POSITION_BITS_DEFAULT = 12;

    localparam int BAND_W   = 12;
    localparam int COUNT_W  = 4;
    localparam int TIME_W   = 8;
    localparam int BYTE_W   = 8;
    localparam int DIR_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [15:0]       TARGET_RESET = 16'h03FF;
    localparam logic [BYTE_W-1:0] FRAME_HEAD   = 8'h40;
    localparam logic [BYTE_W-1:0] FRAME_TAIL   = 8'h41;

    localparam logic [DIR_W-1:0] DIR_NONE   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FIRST  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_SECOND = 2'd2;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_BYTE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND      = 3'd0,
        CFG_FINE_BAND     = 3'd1,
        CFG_STEADY_PULSES = 3'd2,
        CFG_MOVING_PULSES = 3'd3,
        CFG_COARSE_HIGH   = 3'd4,
        CFG_COARSE_LOW    = 3'd5,
        CFG_FINE_HIGH     = 3'd6,
        CFG_FINE_LOW      = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_FINE,
        MODE_COARSE
    } mode_t;

    typedef struct packed {
        logic [BAND_W-1:0]  deadband;
        logic [BAND_W-1:0]  fine_band;
        logic [COUNT_W-1:0] steady_pulses;
        logic [COUNT_W-1:0] moving_pulses;
        logic [TIME_W-1:0]  coarse_high_time;
        logic [TIME_W-1:0]  coarse_low_time;
        logic [TIME_W-1:0]  fine_high_time;
        logic [TIME_W-1:0]  fine_low_time;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        deadband:         12'd11,
        fine_band:        12'd341,
        steady_pulses:    4'd6,
        moving_pulses:    4'd2,
        coarse_high_time: 8'd28,
        coarse_low_time:  8'd63,
        fine_high_time:   8'd25,
        fine_low_time:    8'd66
    };

    typedef struct packed {
        logic [DIR_W-1:0]   dir;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  high;
        logic [TIME_W-1:0]  low;
    } drive_t;

endpackage

FILE: design/espc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espc_in_if / espc_out_if
// Valid/ready request channels for input items and result items.
// ----------------------------------------------------------------------------
interface espc_in_if #(
    parameter int POSITION_BITS = espc_pkg::POSITION_BITS_DEFAULT
);
    import espc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [POSITION_BITS-1:0] encoder_position;
    logic [BYTE_W-1:0]        rx_byte;

    modport source (output valid, req_type, encoder_position, rx_byte, input ready);
    modport sink   (input valid, req_type, encoder_position, rx_byte, output ready);
endinterface

interface espc_out_if #(
    parameter int POSITION_BITS = espc_pkg::POSITION_BITS_DEFAULT
);
    import espc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [DIR_W-1:0]         drive_direction;
    logic [COUNT_W-1:0]       pulse_count;
    logic [TIME_W-1:0]        pulse_high;
    logic [TIME_W-1:0]        pulse_low;
    logic [POSITION_BITS-1:0] error_magnitude;
    logic                     encoder_fault;
    logic [POSITION_BITS-1:0] target_position;
    logic                     target_updated;

    modport source (
        output valid, drive_direction, pulse_count, pulse_high, pulse_low,
               error_magnitude, encoder_fault, target_position, target_updated,
        input  ready
    );
    modport sink (
        input  valid, drive_direction, pulse_count, pulse_high, pulse_low,
               error_magnitude, encoder_fault, target_position, target_updated,
        output ready
    );
endinterface

FILE: design/espc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espc_regs
// Configuration register file, written through the plain write port.
// ----------------------------------------------------------------------------
module espc_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [espc_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [espc_pkg::CFG_DATA_W-1:0]   wr_data,
    output espc_pkg::cfg_t                    cfg
);
    import espc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        unique case (cfg_index_t'(wr_index))
            CFG_DEADBAND:      cfg_next.deadband         = wr_data;
            CFG_FINE_BAND:     cfg_next.fine_band        = wr_data;
            CFG_STEADY_PULSES: cfg_next.steady_pulses    = wr_data[COUNT_W-1:0];
            CFG_MOVING_PULSES: cfg_next.moving_pulses    = wr_data[COUNT_W-1:0];
            CFG_COARSE_HIGH:   cfg_next.coarse_high_time = wr_data[TIME_W-1:0];
            CFG_COARSE_LOW:    cfg_next.coarse_low_time  = wr_data[TIME_W-1:0];
            CFG_FINE_HIGH:     cfg_next.fine_high_time   = wr_data[TIME_W-1:0];
            CFG_FINE_LOW:      cfg_next.fine_low_time    = wr_data[TIME_W-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/espc_link.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espc_link
// Link byte history and target register; decodes the target frame.
// ----------------------------------------------------------------------------
module espc_link #(
    parameter int POSITION_BITS = espc_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_sel,
    input  logic                          byte_en,
    input  logic [espc_pkg::BYTE_W-1:0]   rx_byte,
    output logic [POSITION_BITS-1:0]      target,
    output logic [POSITION_BITS-1:0]      target_after,
    output logic                          updated
);
    import espc_pkg::*;

    logic [BYTE_W-1:0]        hist_reg [3];   // oldest first
    logic [POSITION_BITS-1:0] target_reg;
    logic [POSITION_BITS-1:0] target_next;
    logic [2*BYTE_W-1:0]      frame_value;
    logic                     frame_hit;
    logic                     value_fits;

    assign frame_value = {hist_reg[1], hist_reg[2]};
    assign frame_hit   = (rx_byte == FRAME_TAIL) && (hist_reg[0] == FRAME_HEAD);
    assign value_fits  = (frame_value >> POSITION_BITS) == '0;

    always_comb
    begin
        updated     = byte_sel && frame_hit && value_fits;
        target_next = updated ? frame_value[POSITION_BITS-1:0] : target_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg[0] <= '0;
            hist_reg[1] <= '0;
            hist_reg[2] <= '0;
            target_reg  <= TARGET_RESET[POSITION_BITS-1:0];
        end
        else if (byte_en)
        begin
            hist_reg[0] <= hist_reg[1];
            hist_reg[1] <= hist_reg[2];
            hist_reg[2] <= rx_byte;
            target_reg  <= target_next;
        end
    end

    assign target       = target_reg;
    assign target_after = target_next;

endmodule

FILE: design/espc_servo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espc_servo
// Position error folding, band decision and pulse selection for one tick.
// ----------------------------------------------------------------------------
module espc_servo #(
    parameter int POSITION_BITS = espc_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      tick_en,
    input  logic [POSITION_BITS-1:0]  position,
    input  logic [POSITION_BITS-1:0]  target,
    input  espc_pkg::cfg_t            cfg,
    output espc_pkg::drive_t          drive,
    output logic [POSITION_BITS-1:0]  magnitude,
    output logic                      fault
);
    import espc_pkg::*;

    localparam int CMP_W = (POSITION_BITS > BAND_W) ? POSITION_BITS : BAND_W;
    localparam logic [POSITION_BITS-1:0] POS_HALF =
        POSITION_BITS'((1 << (POSITION_BITS - 1)) - 1);

    logic                     primed_reg;
    logic [POSITION_BITS-1:0] last_error_reg;
    logic [POSITION_BITS-1:0] diff;
    logic [DIR_W-1:0]         side;
    logic [CMP_W-1:0]         mag_cmp;
    logic [CMP_W-1:0]         dead_cmp;
    logic [CMP_W-1:0]         fine_cmp;
    logic [POSITION_BITS:0]   last_plus_one;
    logic                     steady;
    mode_t                    mode;

    assign diff  = target - position;
    assign fault = &position;

    // Upper half folds back: magnitude is all-ones minus the difference.
    always_comb
    begin
        if (diff >= POS_HALF)
        begin
            magnitude = ~diff;
            side      = DIR_FIRST;
        end
        else
        begin
            magnitude = diff;
            side      = DIR_SECOND;
        end
    end

    assign mag_cmp       = CMP_W'(magnitude);
    assign dead_cmp      = CMP_W'(cfg.deadband);
    assign fine_cmp      = CMP_W'(cfg.fine_band);
    assign last_plus_one = {1'b0, last_error_reg} + 1'b1;
    assign steady        = (magnitude == last_error_reg) ||
                           ({1'b0, magnitude} == last_plus_one);

    always_comb
    begin
        priority if (!primed_reg || fault)
            mode = MODE_NONE;
        else if (mag_cmp < fine_cmp)
            mode = (mag_cmp <= dead_cmp) ? MODE_NONE : MODE_FINE;
        else
            mode = MODE_COARSE;
    end

    always_comb
    begin
        unique case (mode)
            MODE_FINE:
            begin
                drive.dir   = side;
                drive.count = steady ? cfg.steady_pulses : cfg.moving_pulses;
                drive.high  = cfg.fine_high_time;
                drive.low   = cfg.fine_low_time;
            end
            MODE_COARSE:
            begin
                drive.dir   = side;
                drive.count = cfg.steady_pulses;
                drive.high  = cfg.coarse_high_time;
                drive.low   = cfg.coarse_low_time;
            end
            default:
            begin
                drive = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg     <= 1'b0;
            last_error_reg <= '0;
        end
        else if (tick_en)
        begin
            primed_reg <= 1'b1;
            if (mode != MODE_NONE)
            begin
                last_error_reg <= magnitude;
            end
        end
    end

endmodule

FILE: design/encoder_servo_pulse_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_servo_pulse_controller
// Servo position loop for an absolute encoder: control ticks produce drive
// pulse commands, link bytes load a new target through a framed command.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+--------------------------------------
//   item     | in  | valid / ready    | req_type, encoder_position, rx_byte
//   result   | out | valid / ready    | drive, pulses, error, fault, target
//   wr_*     | in  | wr_en, no stall  | wr_index, wr_data
//
// A request passes through the input register, then decision logic into the
// result register. One request per cycle while results are taken; the input
// stage advances whenever the result register is empty or being taken.
// Reset loads the register defaults, target 0x3FF and an unprimed loop.
// A stalled result holds the input stage; ready drops only when both are full.
// ----------------------------------------------------------------------------
module encoder_servo_pulse_controller #(
    parameter int POSITION_BITS = espc_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    espc_in_if.sink                          item,
    espc_out_if.source                       result,
    input  logic                             wr_en,
    input  logic [espc_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [espc_pkg::CFG_DATA_W-1:0]  wr_data
);
    import espc_pkg::*;

    cfg_t                     cfg;
    drive_t                   drive;
    logic [POSITION_BITS-1:0] magnitude;
    logic                     fault;
    logic [POSITION_BITS-1:0] target;
    logic [POSITION_BITS-1:0] target_after;
    logic                     updated;

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic                     s1_type_reg;
    logic [POSITION_BITS-1:0] s1_pos_reg;
    logic [BYTE_W-1:0]        s1_byte_reg;
    logic                     s1_advance;
    logic                     in_fire;
    logic                     s2_fire;
    logic                     tick_sel;
    logic                     byte_sel;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    drive_t                   out_drive_reg;
    logic [POSITION_BITS-1:0] out_mag_reg;
    logic                     out_fault_reg;
    logic [POSITION_BITS-1:0] out_target_reg;
    logic                     out_updated_reg;

    assign s1_advance = !out_valid_reg || result.ready;
    assign item.ready = !s1_valid_reg || s1_advance;
    assign in_fire    = item.valid && item.ready;
    assign s2_fire    = s1_valid_reg && s1_advance;
    assign tick_sel   = (s1_type_reg == REQ_TICK);
    assign byte_sel   = (s1_type_reg == REQ_BYTE);

    espc_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    espc_servo #(
        .POSITION_BITS (POSITION_BITS)
    ) u_servo (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_en   (s2_fire && tick_sel),
        .position  (s1_pos_reg),
        .target    (target),
        .cfg       (cfg),
        .drive     (drive),
        .magnitude (magnitude),
        .fault     (fault)
    );

    espc_link #(
        .POSITION_BITS (POSITION_BITS)
    ) u_link (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_sel     (byte_sel),
        .byte_en      (s2_fire && byte_sel),
        .rx_byte      (s1_byte_reg),
        .target       (target),
        .target_after (target_after),
        .updated      (updated)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s2_fire)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_type_reg <= item.req_type;
            s1_pos_reg  <= item.encoder_position;
            s1_byte_reg <= item.rx_byte;
        end
    end

    // Link bytes report no drive, no error and no fault.
    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            out_drive_reg   <= tick_sel ? drive : '0;
            out_mag_reg     <= tick_sel ? magnitude : '0;
            out_fault_reg   <= tick_sel && fault;
            out_target_reg  <= target_after;
            out_updated_reg <= updated;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.drive_direction = out_drive_reg.dir;
    assign result.pulse_count     = out_drive_reg.count;
    assign result.pulse_high      = out_drive_reg.high;
    assign result.pulse_low       = out_drive_reg.low;
    assign result.error_magnitude = out_mag_reg;
    assign result.encoder_fault   = out_fault_reg;
    assign result.target_position = out_target_reg;
    assign result.target_updated  = out_updated_reg;

`ifndef NO_ASSERTIONS
    a_idle_no_pulses : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.drive_direction == DIR_NONE |->
            result.pulse_count == '0 && result.pulse_high == '0 &&
            result.pulse_low == '0)
        else $error("no-drive result carries pulse data");

    a_fault_no_drive : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.encoder_fault |-> result.drive_direction == DIR_NONE)
        else $error("drive sent with encoder fault");

    a_update_is_byte : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.target_updated |->
            result.drive_direction == DIR_NONE && !result.encoder_fault &&
            result.error_magnitude == '0)
        else $error("target update on a control tick");

    a_stage_holds : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg)
        else $error("input stage dropped a stalled request");
`endif

endmodule

FILE: verif/servo_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_result_checker
// Watches the request and result channels and the register write port of the
// servo pulse controller. Keeps its own copy of the loop state and register
// file, works out the drive command for every accepted request and compares
// each accepted result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module servo_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    espc_in_if                              item,
    espc_out_if                             result,
    input  logic                            wr_en,
    input  logic [espc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [espc_pkg::CFG_DATA_W-1:0] wr_data,
    output int                              fail_count,
    output int                              pending,
    output int                              checked
);
    import espc_pkg::*;

    localparam int PB = POSITION_BITS_DEFAULT;
    localparam logic [PB-1:0] POS_MASK = {PB{1'b1}};
    localparam logic [PB-1:0] POS_HALF = POS_MASK >> 1;

    typedef struct packed {
        logic [DIR_W-1:0]   dir;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  high;
        logic [TIME_W-1:0]  low;
        logic [PB-1:0]      mag;
        logic               fault;
        logic [PB-1:0]      target;
        logic               updated;
    } drive_cmd_t;

    cfg_t              regs;
    logic              primed;
    logic [PB-1:0]     aim;
    logic [PB-1:0]     last_mag;
    logic [BYTE_W-1:0] rx_hist [3];
    drive_cmd_t        pending_cmds [$];

    // Advances the loop state by one request and returns the command it yields.
    function automatic drive_cmd_t servo_decide(logic rt, logic [PB-1:0] pos,
                                                logic [BYTE_W-1:0] b);
        drive_cmd_t    r;
        logic [PB-1:0] d;
        logic [PB-1:0] mag;
        logic [DIR_W-1:0] side;
        mode_t         mode;
        logic [15:0]   frame_val;
        r = '0;
        if (rt == REQ_TICK) begin
            d = aim - pos;
            if (d >= POS_HALF) begin
                mag  = POS_MASK - d;
                side = DIR_FIRST;
            end
            else begin
                mag  = d;
                side = DIR_SECOND;
            end
            if (mag < regs.fine_band)
                mode = (mag <= regs.deadband) ? MODE_NONE : MODE_FINE;
            else
                mode = MODE_COARSE;
            r.fault = (pos == POS_MASK);
            if (!primed || r.fault)
                mode = MODE_NONE;
            case (mode)
                MODE_COARSE:
                begin
                    r.dir    = side;
                    r.count  = regs.steady_pulses;
                    r.high   = regs.coarse_high_time;
                    r.low    = regs.coarse_low_time;
                    last_mag = mag;
                end
                MODE_FINE:
                begin
                    r.dir = side;
                    // steady when the error held or grew by one since last drive
                    if (mag == last_mag || {1'b0, mag} == {1'b0, last_mag} + 1'b1)
                        r.count = regs.steady_pulses;
                    else
                        r.count = regs.moving_pulses;
                    r.high   = regs.fine_high_time;
                    r.low    = regs.fine_low_time;
                    last_mag = mag;
                end
                default: ;
            endcase
            r.mag  = mag;
            primed = 1'b1;
        end
        else begin
            if (b == FRAME_TAIL && rx_hist[0] == FRAME_HEAD) begin
                frame_val = {rx_hist[1], rx_hist[2]};
                if (frame_val <= 16'(POS_MASK)) begin
                    aim       = frame_val[PB-1:0];
                    r.updated = 1'b1;
                end
            end
            rx_hist[0] = rx_hist[1];
            rx_hist[1] = rx_hist[2];
            rx_hist[2] = b;
        end
        r.target = aim;
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        drive_cmd_t want;
        if (!rst_n) begin
            regs       = CFG_RESET;
            primed     = 1'b0;
            aim        = TARGET_RESET[PB-1:0];
            last_mag   = '0;
            rx_hist[0] = '0;
            rx_hist[1] = '0;
            rx_hist[2] = '0;
            pending_cmds.delete();
            pending    = 0;
            fail_count = 0;
            checked    = 0;
        end
        else begin
            if (wr_en) begin
                case (wr_index)
                    CFG_DEADBAND:      regs.deadband         = wr_data[BAND_W-1:0];
                    CFG_FINE_BAND:     regs.fine_band        = wr_data[BAND_W-1:0];
                    CFG_STEADY_PULSES: regs.steady_pulses    = wr_data[COUNT_W-1:0];
                    CFG_MOVING_PULSES: regs.moving_pulses    = wr_data[COUNT_W-1:0];
                    CFG_COARSE_HIGH:   regs.coarse_high_time = wr_data[TIME_W-1:0];
                    CFG_COARSE_LOW:    regs.coarse_low_time  = wr_data[TIME_W-1:0];
                    CFG_FINE_HIGH:     regs.fine_high_time   = wr_data[TIME_W-1:0];
                    CFG_FINE_LOW:      regs.fine_low_time    = wr_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (result.valid === 1'b1 && result.ready === 1'b1) begin
                if (pending_cmds.size() == 0) begin
                    $display("%0t ns: result with no request outstanding, expected none, actual %h",
                             $time, {result.drive_direction, result.pulse_count,
                                     result.error_magnitude, result.target_position});
                    fail_count++;
                end
                else begin
                    want = pending_cmds.pop_front();
                    check_field("drive_direction", 16'(want.dir), 16'(result.drive_direction));
                    check_field("pulse_count", 16'(want.count), 16'(result.pulse_count));
                    check_field("pulse_high", 16'(want.high), 16'(result.pulse_high));
                    check_field("pulse_low", 16'(want.low), 16'(result.pulse_low));
                    check_field("error_magnitude", 16'(want.mag), 16'(result.error_magnitude));
                    check_field("encoder_fault", 16'(want.fault), 16'(result.encoder_fault));
                    check_field("target_position", 16'(want.target),
                                16'(result.target_position));
                    check_field("target_updated", 16'(want.updated), 16'(result.target_updated));
                    checked++;
                end
            end
            if (item.valid === 1'b1 && item.ready === 1'b1)
                pending_cmds.push_back(servo_decide(item.req_type, item.encoder_position,
                                                    item.rx_byte));
            pending = pending_cmds.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the encoder servo pulse controller: a directed
// pass over band edges, error folding, encoder fault and target frames, then
// random control ticks and link traffic under several register settings and
// back-pressure patterns. Checking is done by servo_result_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import espc_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    int                    fail_count;
    int                    pending;
    int                    checked;

    int          src_idle_pct;
    int          sink_idle_pct;
    logic [11:0] aim;
    int          last_off;
    int          n_ticks;
    int          n_bytes;
    int          n_settings;

    espc_in_if  item_ch ();
    espc_out_if result_ch ();

    encoder_servo_pulse_controller dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    servo_result_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);

    initial
    begin
        #5_000_000;
        $display("** encoder_servo_pulse_controller: FAILED **");
        $finish;
    end

    // Position that sits off positions away from the current target.
    function automatic logic [11:0] near(int off);
        return aim - off[11:0];
    endfunction

    task automatic send_item(logic rt, logic [11:0] pos, logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
        end
        @(negedge clk);
        item_ch.valid            <= 1'b1;
        item_ch.req_type         <= rt;
        item_ch.encoder_position <= pos;
        item_ch.rx_byte          <= b;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic send_tick(logic [11:0] pos);
        send_item(REQ_TICK, pos, 8'($urandom));
        n_ticks++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(REQ_BYTE, 12'($urandom), b);
        n_bytes++;
    endtask

    task automatic send_frame(logic [7:0] hi, logic [7:0] lo);
        send_byte(FRAME_HEAD);
        send_byte(hi);
        send_byte(lo);
        send_byte(FRAME_TAIL);
        if ({hi, lo} <= 16'h0FFF)
            aim = {hi[3:0], lo};
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= v;
    endtask

    // Stop requests and let every outstanding result drain.
    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Upper bits of the narrow registers carry junk; the block must drop them.
    task automatic load_setting(cfg_t c);
        write_reg(CFG_DEADBAND, c.deadband);
        write_reg(CFG_FINE_BAND, c.fine_band);
        write_reg(CFG_STEADY_PULSES, {8'($urandom), c.steady_pulses});
        write_reg(CFG_MOVING_PULSES, {8'($urandom), c.moving_pulses});
        write_reg(CFG_COARSE_HIGH, {4'($urandom), c.coarse_high_time});
        write_reg(CFG_COARSE_LOW, {4'($urandom), c.coarse_low_time});
        write_reg(CFG_FINE_HIGH, {4'($urandom), c.fine_high_time});
        write_reg(CFG_FINE_LOW, {4'($urandom), c.fine_low_time});
        @(negedge clk);
        wr_en <= 1'b0;
        n_settings++;
    endtask

    function automatic cfg_t random_setting();
        cfg_t c;
        c = cfg_t'({$urandom, $urandom});
        if ($urandom_range(9) < 7)
            c.deadband = 12'($urandom_range(0, 40));
        if ($urandom_range(9) < 7)
            c.fine_band = 12'($urandom_range(0, 700));
        return c;
    endfunction

    task automatic run_random(int n);
        int          left;
        int          pick;
        int          off;
        logic [11:0] pos;
        logic [7:0]  hi;
        left = n;
        while (left > 0) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                pick = $urandom_range(99);
                if (pick < 30)
                    off = last_off + int'($urandom_range(0, 3)) - 1;
                else if (pick < 60)
                    off = int'($urandom_range(0, 1400)) - 700;
                else if (pick < 70)
                    off = 2044 + int'($urandom_range(0, 8));
                if (pick < 70) begin
                    pos      = near(off);
                    last_off = off;
                end
                else if (pick < 75)
                    pos = 12'hFFF;
                else
                    pos = 12'($urandom);
                send_tick(pos);
                left--;
            end
            else if (pick < 85) begin
                // mostly in range; the rest must be rejected
                if ($urandom_range(9) < 2)
                    hi = 8'($urandom_range(16, 255));
                else
                    hi = 8'($urandom_range(0, 15));
                send_frame(hi, 8'($urandom));
                left -= 4;
            end
            else begin
                pick = $urandom_range(3);
                if (pick == 0) begin
                    // short frame: tail lands one byte early
                    send_byte(FRAME_HEAD);
                    send_byte(8'($urandom));
                    send_byte(FRAME_TAIL);
                    left -= 3;
                end
                else if (pick == 1) begin
                    send_byte($urandom_range(0, 1) ? FRAME_HEAD : FRAME_TAIL);
                    left--;
                end
                else begin
                    send_byte(8'($urandom));
                    left--;
                end
            end
        end
    endtask

    task automatic run_phase(cfg_t c, int src_pct, int sink_pct, int n);
        settle();
        load_setting(c);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        run_random(n);
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        wr_en                    = 1'b0;
        wr_index                 = '0;
        wr_data                  = '0;
        item_ch.valid            = 1'b0;
        item_ch.req_type         = REQ_TICK;
        item_ch.encoder_position = '0;
        item_ch.rx_byte          = '0;
        result_ch.ready          = 1'b0;
        src_idle_pct             = 17;
        sink_idle_pct            = 49;
        aim                      = TARGET_RESET[11:0];
        last_off                 = 0;
        n_ticks                  = 0;
        n_bytes                  = 0;
        n_settings               = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset registers, deadband 11 and fine band 341.
        send_tick(near(0));            // first tick after reset never drives
        send_tick(near(12'h3FF));      // coarse, second pin
        send_tick(12'hFFF);            // encoder absent
        send_tick(near(2046));         // just below the fold point
        send_tick(near(2047));         // folds to the largest magnitude
        send_tick(near(2048));
        send_tick(near(20));           // fine, magnitude moved
        send_tick(near(-21));          // same magnitude, first pin: steady
        send_tick(near(21));           // one above last: steady
        send_tick(near(20));           // one below last: moving
        send_tick(near(11));           // at deadband: no drive
        send_tick(near(12));           // just above deadband: fine
        send_tick(near(341));          // at fine band edge: coarse
        send_frame(8'h0F, 8'hFF);      // largest legal target
        send_frame(8'h10, 8'h00);      // value out of range, ignored
        send_frame(8'h00, 8'h00);      // target zero

        run_phase(random_setting(), 17, 49, 300);
        run_phase('0, 17, 49, 250);
        run_phase('{deadband: 12'd0, fine_band: 12'hFFF, steady_pulses: 4'hF,
                    moving_pulses: 4'h0, coarse_high_time: 8'hFF, coarse_low_time: 8'h00,
                    fine_high_time: 8'h00, fine_low_time: 8'hFF}, 49, 17, 300);
        run_phase(random_setting(), 49, 17, 300);
        run_phase(cfg_t'('1), 0, 0, 100);
        run_phase(random_setting(), 0, 0, 300);
        run_phase(CFG_RESET, 0, 0, 300);

        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Run covered %0d control ticks and %0d link bytes under %0d register settings,",
                 n_ticks, n_bytes, n_settings + 1);
        $display("with %0d results compared against the predicted drive commands.", checked);
        if (fail_count == 0 && pending == 0)
            $display("** encoder_servo_pulse_controller: PASSED **");
        else
            $display("** encoder_servo_pulse_controller: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
design/espc_pkg.sv
design/espc_if.sv
design/espc_regs.sv
design/espc_link.sv
design/espc_servo.sv
design/encoder_servo_pulse_controller.sv
verif/servo_result_checker.sv
verif/tb_top.sv
